// ===== src/tma_pkg.sv =====
// Shared widths and defaults for the temperature moving average block.
// No dependencies; every file that uses it refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tma_pkg;

  // Field widths of the input and result words
  localparam int SAMPLE_W = 12;
  localparam int TENTHS_W = 12;
  localparam int AVG_W    = 15;
  localparam int HELD_W   = 7;

  // Default window depth and its upper bound
  localparam int WINDOW_DEF = 8;
  localparam int WINDOW_MAX = 64;

endpackage

`default_nettype wire

// ===== src/tma_if.sv =====
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on tma_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tma_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tma_pkg::SAMPLE_W-1:0] sample_raw;

  modport source (output valid, output sample_raw, input ready);
  modport sink   (input valid, input sample_raw, output ready);
endinterface

interface tma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tma_pkg::TENTHS_W-1:0] rounded_tenths;
  logic signed [tma_pkg::AVG_W-1:0]    average_hundredths;
  logic        [tma_pkg::HELD_W-1:0]   samples_held;

  modport source (output valid, output rounded_tenths, output average_hundredths,
                  output samples_held, input ready);
  modport sink   (input valid, input rounded_tenths, input average_hundredths,
                  input samples_held, output ready);
endinterface

`default_nettype wire

// ===== src/tma_div.sv =====
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
// Used by temperature_moving_average to divide by twice the fill count.
`timescale 1ns / 1ps
`default_nettype none

module tma_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;

  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W-1:0] rem_d;

  // Shift in the next dividend bit and try the subtraction
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = (shifted >= {1'b0, den_q});
  assign rem_d   = ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];

  // Load on start, then advance one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= num_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== src/temperature_moving_average.sv =====
// Top level: sample rounding, windowed running sum and rounded average.
// Depends on tma_pkg, tma_if (channels) and tma_div (serial divider).
//
//   channel   dir  handshake      payload
//   sample_i  in   valid / ready  sample_raw
//   result_o  out  valid / ready  rounded_tenths, average_hundredths, samples_held
//
// One word at a time: accept, window read, sum update, numerator setup, then
// the divider run, a state to see the divider finish and a state to load the
// output register; NUM_W is 12 + clog2(WINDOW) + 6.
// The divider sets the rate unless a result stalls. Reset clears the fill count,
// pointer and sum; the window memory needs no clearing. A stalled result holds in
// the output register while the next sample is already accepted and worked on.
`timescale 1ns / 1ps
`default_nettype none

module temperature_moving_average #(
  parameter int WINDOW = tma_pkg::WINDOW_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tma_in_if.sink     sample_i,
  tma_out_if.source  result_o
);

  localparam int TW    = tma_pkg::TENTHS_W;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = TW + $clog2(WINDOW);
  localparam int NUM_W = SUM_W + 6;
  localparam int DEN_W = CW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_PREP,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic signed [TW-1:0]    tenths_q;
  logic        [PTR_W-1:0] addr_q;
  logic        [CW-1:0]    fill_q;
  logic        [PTR_W-1:0] ptr_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic signed [TW-1:0]    out_tenths_q;
  logic signed [tma_pkg::AVG_W-1:0] out_avg_q;
  logic        [tma_pkg::HELD_W-1:0] out_held_q;

  logic signed [TW-1:0]    mem_q [WINDOW];
  logic signed [TW-1:0]    rdata_q;

  logic                    full;
  logic                    in_acc;
  logic                    out_acc;
  logic                    out_load;
  logic signed [16:0]      prod;
  logic signed [16:0]      prod_shr;
  logic                    round_up;
  logic signed [TW-1:0]    tenths_c;
  logic signed [SUM_W-1:0] old_c;
  logic signed [SUM_W-1:0] sum_d;
  logic signed [NUM_W-1:0] num_c;
  logic        [NUM_W-1:0] num_mag;
  logic        [DEN_W-1:0] den_c;
  logic                    div_start;
  logic                    div_done;
  logic        [NUM_W-1:0] div_quo;
  logic        [NUM_W-1:0] avg_c;

  assign full     = (fill_q == CW'(WINDOW));
  assign in_acc   = sample_i.valid && sample_i.ready;
  assign out_acc  = out_valid_q && result_o.ready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  // Round 1/16 degree to tenths: (10*raw + 8) / 16, truncated toward zero
  assign prod     = (17'(sample_i.sample_raw) <<< 3) + (17'(sample_i.sample_raw) <<< 1)
                    + 17'sd8;
  assign prod_shr = prod >>> 4;
  assign round_up = prod[16] && (prod[3:0] != 4'd0);
  assign tenths_c = TW'(prod_shr + 17'(round_up));

  // Drop the oldest entry once full, add the new one
  assign old_c = full ? SUM_W'(rdata_q) : '0;
  assign sum_d = sum_q - old_c + SUM_W'(tenths_q);

  // Numerator 20*sum + count, denominator 2*count
  assign num_c   = (NUM_W'(sum_q) <<< 4) + (NUM_W'(sum_q) <<< 2)
                   + NUM_W'($signed({1'b0, fill_q}));
  assign num_mag = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
  assign den_c   = {fill_q, 1'b0};
  assign div_start = (state_q == ST_PREP);

  // Restore the sign of the quotient
  assign avg_c = neg_q ? NUM_W'(-div_quo) : div_quo;

  tma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_mag),
    .den_i   (den_c),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Window memory: registered read in READ, write back in UPDATE
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rdata_q <= mem_q[addr_q];
    end
    if (state_q == ST_UPDATE) begin
      mem_q[addr_q] <= tenths_q;
    end
  end

  // Sequence one word and hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tenths_q     <= '0;
      addr_q       <= '0;
      fill_q       <= '0;
      ptr_q        <= '0;
      sum_q        <= '0;
      neg_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_tenths_q <= '0;
      out_avg_q    <= '0;
      out_held_q   <= '0;
    end else begin
      // Load a new result word, or drop valid once the word is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            tenths_q <= tenths_c;
            addr_q   <= full ? ptr_q : PTR_W'(fill_q);
            state_q  <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          sum_q <= sum_d;
          if (full) begin
            ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
          end else begin
            fill_q <= fill_q + CW'(1);
          end
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          neg_q   <= num_c[NUM_W-1];
          state_q <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_tenths_q <= tenths_q;
            out_avg_q    <= tma_pkg::AVG_W'(avg_c);
            out_held_q   <= tma_pkg::HELD_W'(fill_q);
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign sample_i.ready              = (state_q == ST_IDLE);
  assign result_o.valid              = out_valid_q;
  assign result_o.rounded_tenths     = out_tenths_q;
  assign result_o.average_hundredths = out_avg_q;
  assign result_o.samples_held       = out_held_q;

endmodule

`default_nettype wire

// ===== src/tma_checker.sv =====
// Port-level checks for temperature_moving_average, attached by bind.
// Depends on tma_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module tma_checker #(
  parameter int WINDOW = tma_pkg::WINDOW_DEF
) (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_i,
  input wire logic                                 out_valid_i,
  input wire logic                                 out_ready_i,
  input wire logic signed [tma_pkg::TENTHS_W-1:0] tenths_i,
  input wire logic signed [tma_pkg::AVG_W-1:0]    avg_i,
  input wire logic        [tma_pkg::HELD_W-1:0]   held_i
);

  logic                         seen_q;
  logic [tma_pkg::HELD_W-1:0]   last_held_q;

  // Track the window count of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_held_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_q      <= 1'b1;
      last_held_q <= held_i;
    end
  end

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tenths_i) && $stable(avg_i)
      && $stable(held_i))
    else $error("stalled result word changed");

  // One sample in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a sample is in flight");

  // Window count stays within one and the window depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> held_i >= tma_pkg::HELD_W'(1) && held_i <= tma_pkg::HELD_W'(WINDOW))
    else $error("samples_held out of range");

  // Window count grows by one per word until it saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_q |-> (held_i == last_held_q + tma_pkg::HELD_W'(1))
      || (held_i == last_held_q && held_i == tma_pkg::HELD_W'(WINDOW)))
    else $error("samples_held did not advance correctly");

  // Rounded sample stays within what a 12-bit raw value can give
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tenths_i <= 12'sd1279 && tenths_i >= -12'sd1279)
    else $error("rounded_tenths out of range");

endmodule

bind temperature_moving_average tma_checker #(
  .WINDOW (WINDOW)
) u_tma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .tenths_i    (result_o.rounded_tenths),
  .avg_i       (result_o.average_hundredths),
  .held_i      (result_o.samples_held)
);

`default_nettype wire

// ===== dv/temperature_moving_average_test.sv =====
// Self-checking testbench for temperature_moving_average: directed and random samples.
// Depends on tma_pkg, tma_if and the top level; results are checked against a built-in
// model of the sample rounding and the windowed average.
`timescale 1ns / 1ps
`default_nettype none

module temperature_moving_average_test;

  localparam int WINDOW         = tma_pkg::WINDOW_DEF;
  localparam int RANDOM_PER_LAP = 200;
  localparam int DRAIN_CYCLES   = 64;
  localparam int DIRECTED_COUNT = 24;

  typedef struct packed {
    logic signed [tma_pkg::TENTHS_W-1:0] tenths;
    logic signed [tma_pkg::AVG_W-1:0]    avg_hundredths;
    logic        [tma_pkg::HELD_W-1:0]   held;
  } reading_t;

  typedef struct packed {
    logic signed [tma_pkg::SAMPLE_W-1:0] raw;
    logic                                typed;
    reading_t                            want;
  } directed_row_t;

  // Hand-checked rows carry their reading; the rest go through the window model.
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{2047,  1'b1, '{1279, 12790, 1}},
    '{-2048, 1'b1, '{-1279, 0, 2}},
    '{0,     1'b1, '{0, 0, 3}},
    '{-1,    1'b0, '{0, 0, 0}},
    '{1,     1'b0, '{0, 0, 0}},
    '{-8,    1'b0, '{0, 0, 0}},
    '{8,     1'b0, '{0, 0, 0}},
    '{-9,    1'b0, '{0, 0, 0}},
    '{-880,  1'b0, '{0, 0, 0}},
    '{2000,  1'b0, '{0, 0, 0}},
    '{4,     1'b0, '{0, 0, 0}},
    '{-4,    1'b0, '{0, 0, 0}},
    '{2047,  1'b0, '{0, 0, 0}},
    '{2047,  1'b0, '{0, 0, 0}},
    '{2047,  1'b0, '{0, 0, 0}},
    '{2047,  1'b0, '{0, 0, 0}},
    '{2047,  1'b0, '{0, 0, 0}},
    '{2047,  1'b0, '{0, 0, 0}},
    '{2047,  1'b0, '{0, 0, 0}},
    '{2047,  1'b0, '{0, 0, 0}},
    '{-2048, 1'b0, '{0, 0, 0}},
    '{-2048, 1'b0, '{0, 0, 0}},
    '{-2048, 1'b0, '{0, 0, 0}},
    '{-7,    1'b0, '{0, 0, 0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tma_in_if  sample_if ();
  tma_out_if result_if ();

  temperature_moving_average #(
    .WINDOW (WINDOW)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  // Window model state
  int tenths_window [WINDOW];
  int window_fill   = 0;
  int window_oldest = 0;
  int window_sum    = 0;

  reading_t                            pending_readings [$];
  logic signed [tma_pkg::SAMPLE_W-1:0] last_raw      = '0;
  int                                  send_idle_pct = 0;
  int                                  recv_idle_pct = 0;
  int                                  mismatches    = 0;
  int                                  words_seen    = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Round one sample to tenths, slide it into the window, and average
  task automatic advance_window(input logic signed [tma_pkg::SAMPLE_W-1:0] raw,
                                output reading_t r);
    int raw_int;
    int tenths;
    int count;
    raw_int = int'(raw);
    tenths  = (raw_int * 10 + 8) / 16;
    if (window_fill < WINDOW) begin
      tenths_window[window_fill] = tenths;
      window_fill++;
    end else begin
      window_sum -= tenths_window[window_oldest];
      tenths_window[window_oldest] = tenths;
      window_oldest = (window_oldest + 1) % WINDOW;
    end
    window_sum += tenths;
    count = window_fill;
    r.tenths         = tma_pkg::TENTHS_W'(tenths);
    r.avg_hundredths = tma_pkg::AVG_W'((20 * window_sum + count) / (2 * count));
    r.held           = tma_pkg::HELD_W'(count);
  endtask

  // Mix of full-range, near-zero, extreme, held, drifting and mid-range (-880 to 2000) samples
  function automatic logic signed [tma_pkg::SAMPLE_W-1:0] pick_sample();
    int v;
    int prev;
    prev = int'(last_raw);
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 4095)) - 2048;
      1: v = int'($urandom_range(0, 80)) - 40;
      2: begin
        case ($urandom_range(0, 3))
          0:       v = -2048;
          1:       v = 2047;
          2:       v = -880;
          default: v = 2000;
        endcase
      end
      3: v = prev;
      4, 5, 6: v = prev + int'($urandom_range(0, 24)) - 12;
      default: v = int'($urandom_range(0, 2880)) - 880;
    endcase
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[tma_pkg::SAMPLE_W-1:0];
  endfunction

  // Offer one sample word, hold it until taken, then log its reading
  task automatic send_sample(input logic signed [tma_pkg::SAMPLE_W-1:0] raw,
                             input logic typed, input reading_t typed_want);
    reading_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.sample_raw <= raw;
    do @(posedge clk_i); while (sample_if.ready !== 1'b1);
    advance_window(raw, want);
    pending_readings.push_back(typed ? typed_want : want);
    last_raw = raw;
  endtask

  // Drop valid and hold off until every reading has come back
  task automatic drain_readings();
    sample_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  task automatic note_mismatch(input string what, input reading_t want, input reading_t got);
    if (mismatches < 10)
      $display("%s on word %0d: tenths %0d/%0d, avg %0d/%0d, held %0d/%0d (expected/actual)",
               what, words_seen, want.tenths, got.tenths, want.avg_hundredths,
               got.avg_hundredths, want.held, got.held);
    mismatches++;
  endtask

  // Compare one result word against the oldest pending reading
  task automatic check_reading();
    reading_t want;
    reading_t got;
    got.tenths         = result_if.rounded_tenths;
    got.avg_hundredths = result_if.average_hundredths;
    got.held           = result_if.samples_held;
    if (pending_readings.size() == 0) begin
      note_mismatch("unexpected result", '0, got);
    end else begin
      want = pending_readings.pop_front();
      if (got.tenths !== want.tenths || got.avg_hundredths !== want.avg_hundredths ||
          got.held !== want.held)
        note_mismatch("mismatch", want, got);
    end
    words_seen++;
  endtask

  // Result side: take words when ready, then redraw ready for the next cycle
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) check_reading();
      result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus: directed rows, then three laps of random samples with changing back-pressure
  initial begin
    int lap;
    int n;
    sample_if.valid      <= 1'b0;
    sample_if.sample_raw <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (lap = 0; lap < 3; lap++) begin
      case (lap)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (lap == 0) begin
        for (int i = 0; i < DIRECTED_COUNT; i++)
          send_sample(DIRECTED_ROWS[i].raw, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        drain_readings();
      end
      for (n = 0; n < RANDOM_PER_LAP; n++) send_sample(pick_sample(), 1'b0, '0);
      drain_readings();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS temperature_moving_average");
    else
      $display("FAIL temperature_moving_average");
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #10_000_000;
    $display("FAIL temperature_moving_average");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/tma_pkg.sv
src/tma_if.sv
src/tma_div.sv
src/temperature_moving_average.sv
src/tma_checker.sv
dv/temperature_moving_average_test.sv
